// ----- src/mqe_pkg.sv -----
// Package: shared types, codes and probability tables of the MQ encoder.
`default_nettype none
package mqe_pkg;

    localparam int CONTEXT_COUNT = 2048;
    localparam int CTX_AW = $clog2(CONTEXT_COUNT);
    localparam int MAX_RESULTS = 21;
    localparam int RES_W = 5;

    typedef enum logic [1:0] {
        OP_ENC    = 2'd0,
        OP_ENC_FL = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EVAL, S_SHIFT, S_FL_INIT, S_FL_LOOP,
        S_FL_TAIL, S_MARK, S_FIN, S_FIN_FL
    } t_state;

    typedef struct packed {
        logic start;
        logic clear;
        logic eval;
        logic shift;
        logic fl_init;
        logic fl_loop;
        logic fl_tail;
        logic mark;
        logic next_bit;
        logic rst_state;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       renorm;
        logic       sh_done;
        logic       last_bit;
        logic       k_init_pos;
        logic       k_loop_pos;
        logic [1:0] op;
    } t_sts;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [31:0] stream_length;
    } t_res;

    typedef struct packed {
        logic [27:0] c;
        logic [7:0]  b;
        logic [3:0]  ct;
        logic        emit;
        logic [7:0]  val;
    } t_bo;

    localparam logic [15:0] QE [0:52] = '{
        16'h5601,16'h3401,16'h1801,16'h0ac1,16'h0521,16'h0221,16'h5601,16'h5401,
        16'h4801,16'h3801,16'h3001,16'h2401,16'h1c01,16'h1601,16'h5601,16'h54ff,
        16'h5401,16'h527d,16'h5101,16'h4c5f,16'h4801,16'h3f80,16'h3801,16'h35f7,
        16'h3401,16'h31f6,16'h3001,16'h2801,16'h2401,16'h2201,16'h1c01,16'h1801,
        16'h1601,16'h1401,16'h1201,16'h1101,16'h0ac1,16'h09c1,16'h08a1,16'h0521,
        16'h0441,16'h02a1,16'h0221,16'h0141,16'h0111,16'h0085,16'h0049,16'h0025,
        16'h0015,16'h0009,16'h0005,16'h0001,16'h5601
    };
    localparam logic [5:0] NMPS [0:52] = '{
        6'd1,6'd2,6'd3,6'd4,6'd5,6'd44,6'd7,6'd8,6'd9,6'd10,
        6'd11,6'd12,6'd13,6'd35,6'd15,6'd16,6'd17,6'd18,6'd19,6'd20,
        6'd21,6'd22,6'd23,6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd30,
        6'd31,6'd32,6'd33,6'd34,6'd35,6'd36,6'd37,6'd38,6'd39,6'd40,
        6'd41,6'd42,6'd43,6'd44,6'd45,6'd45,6'd47,6'd48,6'd49,6'd50,
        6'd51,6'd51,6'd52
    };
    localparam logic [5:0] NLPS [0:52] = '{
        6'd1,6'd6,6'd9,6'd12,6'd35,6'd39,6'd6,6'd14,6'd14,6'd14,
        6'd20,6'd22,6'd25,6'd27,6'd14,6'd14,6'd14,6'd15,6'd16,6'd17,
        6'd18,6'd19,6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,6'd26,6'd27,
        6'd28,6'd29,6'd30,6'd31,6'd32,6'd33,6'd34,6'd35,6'd36,6'd37,
        6'd38,6'd39,6'd40,6'd41,6'd42,6'd43,6'd44,6'd45,6'd46,6'd47,
        6'd48,6'd49,6'd52
    };

    function automatic logic swap_of(input logic [5:0] st);
        return (st == 6'd0) || (st == 6'd6) || (st == 6'd14);
    endfunction

    function automatic t_bo byte_out(input logic [27:0] c, input logic [7:0] b,
                                     input logic buffered);
        t_bo         r;
        logic [7:0]  bb;
        logic [27:0] cc;
        bb = b;
        cc = c;
        if (b != 8'hff && c[27]) begin
            bb = b + 8'd1;
            cc[27] = 1'b0;
        end
        if (bb == 8'hff) begin
            r.emit = 1'b1;
            r.val  = 8'hff;
            r.b    = cc[27:20];
            r.c    = {8'd0, cc[19:0]};
            r.ct   = 4'd7;
        end else begin
            r.emit = buffered;
            r.val  = bb;
            r.b    = cc[26:19];
            r.c    = {9'd0, cc[18:0]};
            r.ct   = 4'd8;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/mqe_in_if.sv -----
// Interface: input channel carrying opcode and symbol.
`default_nettype none
interface mqe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] symbol;
    modport source (output valid, output opcode, output symbol, input ready);
    modport sink (input valid, input opcode, input symbol, output ready);
endinterface
`default_nettype wire

// ----- src/mqe_out_if.sv -----
// Interface: output channel carrying coded bytes and the closing marker.
`default_nettype none
interface mqe_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_of_run;
    logic [31:0] stream_length;
    modport source (output valid, output out_byte, output byte_valid,
                    output last_of_run, output stream_length, input ready);
    modport sink (input valid, input out_byte, input byte_valid,
                  input last_of_run, input stream_length, output ready);
endinterface
`default_nettype wire

// ----- src/mq_encoder_prev_byte_context_top.sv -----
// Top level: MQ arithmetic encoder with previous-byte context selection.
//  channel | dir | fields                                             | handshake
//  i_in    | in  | opcode[1:0], symbol[7:0]                           | valid/ready
//  o_out   | out | out_byte[7:0], byte_valid, last_of_run, length[31:0] | valid/ready
// An encoded byte takes the accept state, then for each of its 8 bits a context read
// and update plus any renormalization shifts, and a closing step for the transaction.
// A flush runs FL_INIT, one FL_LOOP step per termination byte, FL_TAIL, MARK and FIN_FL.
// After reset and after every flush, a pass over all 2048 contexts clears the context
// memory; no transaction is accepted during it.
// Output stalls hold the coder at its next renormalization shift, flush step or closing step.
`default_nettype none
module mq_encoder_prev_byte_context_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mqe_in_if.sink    i_in,
    mqe_out_if.source o_out
);
    import mqe_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_res res;
    logic push, fin, res_rdy;

    mqe_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in.valid),
        .i_opcode(i_in.opcode), .o_ready(i_in.ready), .i_sts(sts),
        .i_res_rdy(res_rdy), .o_cmd(cmd), .o_fin(fin)
    );

    mqe_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_opcode(i_in.opcode),
        .i_symbol(i_in.symbol), .o_sts(sts), .o_push(push), .o_res(res)
    );

    mqe_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_res(res),
        .i_fin(fin), .o_rdy(res_rdy), .o_out(o_out)
    );

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.byte_valid |-> o_out.last_of_run)
        else $error("closing marker not last");

    a_byte_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.byte_valid |-> o_out.stream_length == 32'd0)
        else $error("length on coded byte");

    a_unused_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.opcode == OP_NONE |=> i_in.ready)
        else $error("unused opcode left idle");

endmodule
`default_nettype wire

// ----- src/mqe_ctrl.sv -----
// Controller: sequences bits, renormalization, flush, context clearing.
`default_nettype none
module mqe_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [1:0]     i_opcode,
    output logic                o_ready,
    input  wire mqe_pkg::t_sts  i_sts,
    input  wire logic           i_res_rdy,
    output mqe_pkg::t_cmd       o_cmd,
    output logic                o_fin
);
    import mqe_pkg::*;

    t_state r_state, n_state;
    t_state bit_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        bit_end = S_READ;
        if (i_sts.last_bit) begin
            bit_end = (i_sts.op == OP_ENC_FL) ? S_FL_INIT : S_FIN;
        end
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_fin   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    case (i_opcode)
                        OP_ENC, OP_ENC_FL: n_state = S_READ;
                        OP_FLUSH:          n_state = S_FL_INIT;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.renorm) begin
                    n_state = S_SHIFT;
                end else begin
                    o_cmd.next_bit = 1'b1;
                    n_state = bit_end;
                end
            end
            S_SHIFT: begin
                if (i_res_rdy) begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.sh_done) begin
                        o_cmd.next_bit = 1'b1;
                        n_state = bit_end;
                    end
                end
            end
            S_FL_INIT: begin
                o_cmd.fl_init = 1'b1;
                n_state = i_sts.k_init_pos ? S_FL_LOOP : S_FL_TAIL;
            end
            S_FL_LOOP: begin
                if (i_res_rdy) begin
                    o_cmd.fl_loop = 1'b1;
                    if (!i_sts.k_loop_pos) n_state = S_FL_TAIL;
                end
            end
            S_FL_TAIL: begin
                if (i_res_rdy) begin
                    o_cmd.fl_tail = 1'b1;
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if (i_res_rdy) begin
                    o_cmd.mark = 1'b1;
                    n_state = S_FIN_FL;
                end
            end
            S_FIN: begin
                if (i_res_rdy) begin
                    o_fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIN_FL: begin
                if (i_res_rdy) begin
                    o_fin = 1'b1;
                    o_cmd.rst_state = 1'b1;
                    n_state = S_CLEAR;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule
`default_nettype wire

// ----- src/mqe_dp.sv -----
// Datapath: interval, code register, byte buffer and context memory.
`default_nettype none
module mqe_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mqe_pkg::t_cmd  i_cmd,
    input  wire logic [1:0]     i_opcode,
    input  wire logic [7:0]     i_symbol,
    output mqe_pkg::t_sts       o_sts,
    output logic                o_push,
    output mqe_pkg::t_res       o_res
);
    import mqe_pkg::*;

    logic [6:0]        r_mem [0:CONTEXT_COUNT-1];
    logic [6:0]        r_rd;
    logic [CTX_AW-1:0] r_clr;
    logic [15:0]       r_a, n_a;
    logic [27:0]       r_c, n_c;
    logic [3:0]        r_ct, n_ct;
    logic [7:0]        r_b, n_b;
    logic              r_buf, n_buf;
    logic [7:0]        r_prev;
    logic [7:0]        r_sym;
    logic [1:0]        r_op;
    logic [2:0]        r_bit;
    logic [31:0]       r_cnt;
    logic [RES_W-1:0]  r_res_n, r_lim;
    logic signed [4:0] r_k, n_k;

    logic [5:0]  st, n_st;
    logic        mps, n_mps, bit_v, hit;
    logic [15:0] q, a_sub;
    logic        we;
    logic [CTX_AW-1:0] wa;
    logic [6:0]  wd;
    logic        want, emit;
    logic [7:0]  want_val;
    t_bo         bo_sh, bo_fl;
    logic [15:0] a1;
    logic [27:0] c1, c_fl;
    logic [3:0]  ct1;
    logic [7:0]  b_tail;

    always_comb begin
        st    = (r_rd[5:0] > 6'd52) ? 6'd52 : r_rd[5:0];
        mps   = r_rd[6];
        q     = QE[st];
        a_sub = r_a - q;
        bit_v = r_sym[r_bit];
        hit   = (bit_v == mps);
        n_mps = mps;
        if (hit) begin
            n_st = NMPS[st];
        end else begin
            n_st  = NLPS[st];
            n_mps = mps ^ swap_of(st);
        end
        a1  = {r_a[14:0], 1'b0};
        c1  = {r_c[26:0], 1'b0};
        ct1 = r_ct - 4'd1;
        bo_sh = byte_out(c1, r_b, r_buf);
        bo_fl = byte_out(r_c, r_b, r_buf);
        c_fl  = bo_fl.c << bo_fl.ct;
        b_tail = (r_b != 8'hff && r_c[27]) ? r_b + 8'd1 : r_b;

        o_sts.clr_done   = (r_clr == {CTX_AW{1'b1}});
        o_sts.renorm     = !(hit && a_sub[15]);
        o_sts.sh_done    = a1[15];
        o_sts.last_bit   = (r_bit == 3'd7);
        o_sts.k_init_pos = (r_ct < 4'd12);
        o_sts.k_loop_pos = (r_k - $signed({1'b0, bo_fl.ct})) > 5'sd0;
        o_sts.op         = r_op;

        we = i_cmd.clear || (i_cmd.eval && o_sts.renorm);
        wa = i_cmd.clear ? r_clr : {r_prev, r_bit};
        wd = i_cmd.clear ? 7'd0 : {n_mps, n_st};

        n_a = r_a; n_c = r_c; n_ct = r_ct; n_b = r_b; n_buf = r_buf; n_k = r_k;
        want = 1'b0; want_val = 8'd0;
        if (i_cmd.eval) begin
            n_a = a_sub;
            if (hit) begin
                if (a_sub[15]) n_c = r_c + {12'd0, q};
                else if (a_sub < q) n_a = q;
                else n_c = r_c + {12'd0, q};
            end else begin
                if (a_sub < q) n_c = r_c + {12'd0, q};
                else n_a = q;
            end
        end
        if (i_cmd.shift) begin
            n_a = a1; n_c = c1; n_ct = ct1;
            if (ct1 == 4'd0) begin
                n_c = bo_sh.c; n_b = bo_sh.b; n_ct = bo_sh.ct; n_buf = 1'b1;
                want = bo_sh.emit; want_val = bo_sh.val;
            end
        end
        if (i_cmd.fl_init) begin
            n_c = r_c << r_ct;
            n_k = 5'sd12 - $signed({1'b0, r_ct});
        end
        if (i_cmd.fl_loop) begin
            n_c = c_fl; n_b = bo_fl.b; n_ct = bo_fl.ct; n_buf = 1'b1;
            n_k = r_k - $signed({1'b0, bo_fl.ct});
            want = bo_fl.emit; want_val = bo_fl.val;
        end
        if (i_cmd.fl_tail) begin
            n_b = b_tail;
            want = (b_tail != 8'hff) && r_buf; want_val = b_tail;
        end
        emit = want && (r_res_n < r_lim);
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[{r_prev, r_bit}];
    end

    always_ff @(posedge i_clk) begin
        r_sym <= i_cmd.start ? i_symbol : r_sym;
        r_k   <= n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.rst_state) begin
            r_a <= 16'h8000; r_c <= '0; r_ct <= 4'd12; r_b <= '0; r_buf <= 1'b0;
            r_prev <= '0; r_cnt <= '0; r_bit <= '0; r_op <= OP_NONE;
            r_res_n <= '0; r_lim <= '0;
            r_clr <= '0;
        end else begin
            r_a <= n_a; r_c <= n_c; r_ct <= n_ct; r_b <= n_b; r_buf <= n_buf;
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            if (i_cmd.start) begin
                r_op    <= i_opcode;
                r_res_n <= '0;
                r_lim   <= (i_opcode == OP_ENC) ? RES_W'(MAX_RESULTS)
                                                : RES_W'(MAX_RESULTS - 1);
            end else if (emit || i_cmd.mark) begin
                r_res_n <= r_res_n + 1'b1;
            end
            if (want && r_cnt != 32'hffff_ffff) r_cnt <= r_cnt + 32'd1;
            if (i_cmd.next_bit) begin
                r_bit <= r_bit + 3'd1;
                if (r_bit == 3'd7) r_prev <= r_sym;
            end
        end
    end

    assign o_push = emit || i_cmd.mark;
    always_comb begin
        o_res.out_byte      = i_cmd.mark ? 8'd0 : want_val;
        o_res.byte_valid    = !i_cmd.mark;
        o_res.stream_length = i_cmd.mark ? r_cnt : 32'd0;
    end

endmodule
`default_nettype wire

// ----- src/mqe_outq.sv -----
// Result stage: holds the newest result until its last flag is known.
`default_nettype none
module mqe_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mqe_pkg::t_res  i_res,
    input  wire logic           i_fin,
    output logic                o_rdy,
    mqe_out_if.source           o_out
);
    import mqe_pkg::*;

    logic r_hold_v, r_out_v, r_out_last;
    t_res r_hold, r_out;
    logic out_free, move;

    assign out_free = !r_out_v || o_out.ready;
    assign o_rdy    = !r_hold_v || out_free;
    assign move     = r_hold_v && (i_push || i_fin) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (move) r_out_v <= 1'b1;
            else if (o_out.ready) r_out_v <= 1'b0;
            if (i_push) r_hold_v <= 1'b1;
            else if (i_fin) r_hold_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_hold <= i_res;
        if (move) begin
            r_out      <= r_hold;
            r_out_last <= i_fin;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.byte_valid    = r_out.byte_valid;
    assign o_out.last_of_run   = r_out_last;
    assign o_out.stream_length = r_out.stream_length;

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Testbench: self-checking random and directed test of the MQ encoder top level.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import mqe_pkg::*;

    typedef struct {
        t_op        op;
        logic [7:0] sym;
        bit         hold;
    } t_item;

    typedef struct {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last_of_run;
        logic [31:0] stream_length;
    } t_coded;

    logic i_clk;
    logic i_rst_n;

    mqe_in_if  in_ch ();
    mqe_out_if out_ch ();

    mq_encoder_prev_byte_context_top u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_item  pend_q[$];
    t_coded coded_q[$];
    t_coded run_q[$];
    t_item  cur;
    bit     busy;
    int     send_gap;
    int     recv_gap;
    int     errors;
    int     n_items;
    int     n_flushes;
    int     n_bytes;

    logic [15:0] cx_a;
    logic [27:0] cx_c;
    logic [3:0]  cx_ct;
    logic [7:0]  cx_b;
    bit          cx_buf;
    logic [7:0]  prev_sym;
    logic [31:0] coded_total;
    logic [6:0]  ctx_mem [0:CONTEXT_COUNT-1];
    int          run_lim;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic clear_coder();
        cx_a = 16'h8000;
        cx_c = '0;
        cx_ct = 4'd12;
        cx_b = '0;
        cx_buf = 0;
        prev_sym = '0;
        coded_total = '0;
        for (int i = 0; i < CONTEXT_COUNT; i++) ctx_mem[i] = '0;
    endtask

    task automatic put(input logic [7:0] v, input logic bv, input logic [31:0] len);
        t_coded r;
        r.out_byte = v;
        r.byte_valid = bv;
        r.last_of_run = 1'b0;
        r.stream_length = len;
        if (run_q.size() < run_lim) run_q.push_back(r);
    endtask

    task automatic emit_coded(input logic [7:0] v);
        put(v, 1'b1, '0);
        if (coded_total != 32'hffffffff) coded_total++;
    endtask

    task automatic shift_byte();
        if (cx_b != 8'hff && cx_c[27]) begin
            cx_b++;
            cx_c[27] = 1'b0;
        end
        if (cx_b == 8'hff) begin
            emit_coded(8'hff);
            cx_b = cx_c[27:20];
            cx_c = {8'd0, cx_c[19:0]};
            cx_ct = 4'd7;
        end else begin
            if (cx_buf) emit_coded(cx_b);
            cx_b = cx_c[26:19];
            cx_c = {9'd0, cx_c[18:0]};
            cx_ct = 4'd8;
        end
        cx_buf = 1;
    endtask

    task automatic code_decision(input int cx, input bit d);
        logic [6:0]  e;
        logic [5:0]  st;
        bit          m;
        logic [15:0] q;
        e = ctx_mem[cx];
        st = e[5:0];
        m = e[6];
        if (st > 6'd52) st = 6'd52;
        q = QE[st];
        cx_a = cx_a - q;
        if (d == m) begin
            if (cx_a[15]) begin
                cx_c = cx_c + 28'(q);
                return;
            end
            if (cx_a < q) cx_a = q;
            else cx_c = cx_c + 28'(q);
            st = NMPS[st];
        end else begin
            if (cx_a < q) cx_c = cx_c + 28'(q);
            else cx_a = q;
            if (st == 6'd0 || st == 6'd6 || st == 6'd14) m = ~m;
            st = NLPS[st];
        end
        ctx_mem[cx] = {m, st};
        do begin
            cx_a = cx_a << 1;
            cx_c = cx_c << 1;
            cx_ct = cx_ct - 4'd1;
            if (cx_ct == 0) shift_byte();
        end while (!cx_a[15]);
    endtask

    task automatic flush_coder();
        int k;
        cx_c = cx_c << cx_ct;
        for (k = 12 - int'(cx_ct); k > 0;) begin
            shift_byte();
            k -= int'(cx_ct);
            cx_c = cx_c << cx_ct;
        end
        if (cx_b != 8'hff && cx_c[27]) cx_b++;
        if (cx_b != 8'hff && cx_buf) emit_coded(cx_b);
    endtask

    task automatic predict_coded(input t_item it);
        logic [31:0] total;
        if (it.op == OP_NONE) return;
        n_items++;
        run_q.delete();
        run_lim = (it.op == OP_ENC) ? MAX_RESULTS : MAX_RESULTS - 1;
        if (it.op == OP_ENC || it.op == OP_ENC_FL) begin
            for (int i = 0; i < 8; i++)
                code_decision(int'({prev_sym, 3'(i)}), it.sym[i]);
            prev_sym = it.sym;
        end
        if (it.op == OP_ENC_FL || it.op == OP_FLUSH) begin
            n_flushes++;
            flush_coder();
            total = coded_total;
            run_lim = MAX_RESULTS;
            put(8'h00, 1'b0, total);
            clear_coder();
        end
        if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
        foreach (run_q[i]) coded_q.push_back(run_q[i]);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            busy = 0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_coded(cur);
                busy = 0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pend_q.size() > 0 && (!pend_q[0].hold || coded_q.size() == 0)) begin
                    cur = pend_q.pop_front();
                    busy = 1;
                    in_ch.opcode <= cur.op;
                    in_ch.symbol <= cur.sym;
                    if (pend_q.size() > 30 && $urandom_range(0, 4) == 0)
                        send_gap = $urandom_range(1, 9);
                end
            end
            in_ch.valid <= busy;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_coded e;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (coded_q.size() == 0) begin
                    $error("unexpected transaction: out_byte %0h", out_ch.out_byte);
                    errors++;
                end else begin
                    e = coded_q.pop_front();
                    n_bytes++;
                    if (out_ch.out_byte !== e.out_byte) begin
                        $error("out_byte: expected %0h, actual %0h", e.out_byte, out_ch.out_byte);
                        errors++;
                    end
                    if (out_ch.byte_valid !== e.byte_valid) begin
                        $error("byte_valid: expected %0b, actual %0b",
                               e.byte_valid, out_ch.byte_valid);
                        errors++;
                    end
                    if (out_ch.last_of_run !== e.last_of_run) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               e.last_of_run, out_ch.last_of_run);
                        errors++;
                    end
                    if (out_ch.stream_length !== e.stream_length) begin
                        $error("stream_length: expected %0d, actual %0d",
                               e.stream_length, out_ch.stream_length);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (pend_q.size() > 30 && $urandom_range(0, 6) == 0)
                    recv_gap = $urandom_range(1, 9);
            end
        end
    end

    task automatic add_item(input t_op op, input logic [7:0] sym, input bit hold);
        t_item it;
        it.op = op;
        it.sym = sym;
        it.hold = hold;
        pend_q.push_back(it);
    endtask

    initial begin
        int          cnt;
        int          len;
        int          mode;
        logic [7:0]  s;
        logic [7:0]  alt;
        bit          first;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_ENC;
        in_ch.symbol = '0;
        out_ch.ready = 1'b0;
        errors = 0;
        n_items = 0;
        n_flushes = 0;
        n_bytes = 0;
        busy = 0;
        clear_coder();

        // flush of an empty stream, ignored opcode, field extremes
        add_item(OP_FLUSH, 8'h00, 0);
        add_item(OP_NONE, 8'hff, 0);
        add_item(OP_ENC, 8'h00, 0);
        add_item(OP_ENC, 8'hff, 0);
        add_item(OP_ENC, 8'h55, 0);
        add_item(OP_ENC, 8'haa, 0);
        add_item(OP_ENC_FL, 8'h81, 0);
        add_item(OP_ENC_FL, 8'hff, 0);
        for (int i = 0; i < 12; i++) add_item(OP_ENC, 8'h00, 0);
        add_item(OP_NONE, 8'h3c, 0);
        add_item(OP_FLUSH, 8'hff, 1);
        cnt = 21;
        first = 1;
        while (cnt < 260) begin
            len = $urandom_range(0, 24);
            mode = $urandom_range(0, 3);
            s = 8'($urandom);
            alt = 8'($urandom);
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: s = 8'($urandom);
                    2: s = $urandom_range(0, 1) ? s : alt;
                    3: s = s + 8'd1;
                    default: ;
                endcase
                if ($urandom_range(0, 11) == 0) add_item(OP_NONE, 8'($urandom), 0);
                add_item(OP_ENC, s, first);
                first = 0;
                cnt++;
            end
            add_item($urandom_range(0, 1) ? OP_ENC_FL : OP_FLUSH, 8'($urandom),
                     $urandom_range(0, 9) == 0);
            cnt++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pend_q.size() == 0 && !busy);
        wait (coded_q.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("tb_top: %0d items sent, %0d streams closed, %0d results checked",
                 n_items, n_flushes, n_bytes);
        if (errors == 0 && coded_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/mqe_pkg.sv
src/mqe_in_if.sv
src/mqe_out_if.sv
src/mqe_ctrl.sv
src/mqe_dp.sv
src/mqe_outq.sv
src/mq_encoder_prev_byte_context_top.sv
dv/tb_top.sv
